// File: hw/rtl/apm_pkg.sv
// apm_pkg: shared constants, types and the dB step table for the audio peak meter.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package apm_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
  localparam int LEVEL_W      = 15;
  localparam int SUM_W        = LEVEL_W + $clog2(MAX_CHANNELS);
  localparam int DB_W         = 11;
  localparam int PIX_W        = 12;
  localparam int D_W          = 10;
  localparam int Q_FRAC       = 24;
  localparam int P_W          = Q_FRAC + 1;
  localparam int F_W          = 24;
  localparam int STEPS        = 10;
  localparam int STEP_W       = $clog2(STEPS);
  localparam int BAR_PROD_W   = LEVEL_W + PIX_W;
  localparam int DIV_N_W      = SUM_W;
  localparam int DIV_D_W      = CNT_W;
  localparam int APB_ADDR_W   = 4;
  localparam int APB_DATA_W   = 32;

  // x / 25600 = (x >> 10) / 25; the divide by 25 is a reciprocal multiply,
  // exact for every shifted bar product (below 2^17)
  localparam int BAR_PRE_SHIFT = 10;
  localparam int BAR_Q_W       = BAR_PROD_W - BAR_PRE_SHIFT;
  localparam int RECIP_W       = 18;
  localparam int RECIP_SHIFT   = 22;
  localparam int BAR_SCALE_W   = BAR_Q_W + RECIP_W;

  localparam logic [LEVEL_W-1:0] FULL_PERCENT_Q8 = 15'd25600;
  localparam logic [LEVEL_W-1:0] ONE_PERCENT_Q8  = 15'd256;
  localparam logic [LEVEL_W-1:0] MAX_FALL_RESET  = 15'd3840;
  localparam logic [PIX_W-1:0]   MARGIN_PX       = 12'd20;
  localparam logic [PIX_W-1:0]   EDGE_PX         = 12'd40;
  localparam logic [D_W-1:0]     DB_FLOOR        = 10'd1000;
  localparam logic [RECIP_W-1:0] RECIP_25        = 18'd167773;  // ceil(2^22 / 25)

  typedef enum logic [1:0] {
    REG_VIDEO_READY  = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2,
    REG_MAX_FALL     = 2'd3
  } apm_reg_t;

  typedef struct packed {
    logic               video_ready;
    logic [PIX_W-1:0]   frame_width;
    logic [PIX_W-1:0]   frame_height;
    logic [LEVEL_W-1:0] max_fall_q8;
  } apm_cfg_t;

  typedef struct packed {
    logic capture;
    logic conv_step;
    logic scale;
    logic accum;
    logic div_start;
    logic hold;
    logic bar_mul;
    logic bar_scale;
    logic load_out;
  } apm_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic last;
    logic div_busy;
  } apm_stat_t;

  // 10^(-2^k/200) in Q24
  function automatic logic [F_W-1:0] pow_step(input logic [STEP_W-1:0] k);
    logic [F_W-1:0] f;
    unique case (k)
      4'd0:    f = 24'd16585169;
      4'd1:    f = 24'd16395320;
      4'd2:    f = 24'd16022117;
      4'd3:    f = 24'd15301003;
      4'd4:    f = 24'd13954680;
      4'd5:    f = 24'd11606998;
      4'd6:    f = 24'd8030080;
      4'd7:    f = 24'd3843438;
      4'd8:    f = 24'd880481;
      4'd9:    f = 24'd46208;
      default: f = 24'd16777215;
    endcase
    return f;
  endfunction

endpackage

// File: hw/rtl/apm_in_if.sv
// apm_in_if: input channel, one channel peak word per transfer.
// Depends on apm_pkg for field widths.
`timescale 1ns / 1ps

interface apm_in_if
  import apm_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [DB_W-1:0] peak_db_tenths;
  logic                   last_channel;

  modport source(output valid, output peak_db_tenths, output last_channel, input ready);
  modport sink(input valid, input peak_db_tenths, input last_channel, output ready);
endinterface

// File: hw/rtl/apm_out_if.sv
// apm_out_if: result channel, one level and bar geometry word per report.
// Depends on apm_pkg for field widths.
`timescale 1ns / 1ps

interface apm_out_if
  import apm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level_q8;
  logic               bar_shown;
  logic [PIX_W-1:0]   bar_x;
  logic [PIX_W-1:0]   bar_y;
  logic [PIX_W-1:0]   bar_height;

  modport source(output valid, output level_q8, output bar_shown, output bar_x,
                 output bar_y, output bar_height, input ready);
  modport sink(input valid, input level_q8, input bar_shown, input bar_x,
               input bar_y, input bar_height, output ready);
endinterface

// File: hw/rtl/audio_peak_meter_bar.sv
// audio_peak_meter_bar: peak level meter with limited fall rate and bar geometry.
// Each channel word runs through 10 serial Q24 multiply steps, then scale and sum.
// A closing word then passes through the bit-serial average (launch, 18 divide steps,
// done), hold, bar multiply, reciprocal scale and output load; output load waits
// while an untaken result is held, and the next word is taken once back in idle.
// Synchronous reset clears the sum, count, held level and handshake state.
`timescale 1ns / 1ps

module audio_peak_meter_bar
  import apm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  apm_in_if.sink                in_ch,
  apm_out_if.source             out_ch
);

  apm_cfg_t  cfg;
  apm_cmd_t  cmd;
  apm_stat_t stat;

  apm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  apm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  apm_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .in_peak    (in_ch.peak_db_tenths),
    .in_last    (in_ch.last_channel),
    .level_q8   (out_ch.level_q8),
    .bar_shown  (out_ch.bar_shown),
    .bar_x      (out_ch.bar_x),
    .bar_y      (out_ch.bar_y),
    .bar_height (out_ch.bar_height)
  );

endmodule

// File: hw/rtl/apm_regs.sv
// apm_regs: APB configuration registers of the peak meter.
// Depends on apm_pkg for the register map and config struct.
`timescale 1ns / 1ps

module apm_regs
  import apm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output apm_cfg_t              cfg
);

  apm_reg_t idx;
  logic     wr_en;

  assign idx    = apm_reg_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.video_ready  <= 1'b0;
      cfg.frame_width  <= '0;
      cfg.frame_height <= '0;
      cfg.max_fall_q8  <= MAX_FALL_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_VIDEO_READY:  cfg.video_ready  <= pwdata[0];
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[PIX_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[PIX_W-1:0];
        REG_MAX_FALL:     cfg.max_fall_q8  <= pwdata[LEVEL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_VIDEO_READY:  prdata = APB_DATA_W'(cfg.video_ready);
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(cfg.frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(cfg.frame_height);
      REG_MAX_FALL:     prdata = APB_DATA_W'(cfg.max_fall_q8);
    endcase
  end

endmodule

// File: hw/rtl/apm_div.sv
// apm_div: restoring divider, one quotient bit per cycle, used for the
// channel average (sum over channel count). Depends on apm_pkg.
`timescale 1ns / 1ps

module apm_div
  import apm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               busy,
  output logic [DIV_N_W-1:0] quotient
);

  localparam int DCNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] dvs;
  logic [DIV_N_W-1:0] quo;
  logic [DCNT_W-1:0]  cnt;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               ge;

  assign trial    = {rem, quo[DIV_N_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      rem  <= '0;
      dvs  <= divisor;
      quo  <= dividend;
      cnt  <= DCNT_W'(DIV_N_W);
      busy <= 1'b1;
    end else if (busy) begin
      // shift the next dividend bit into the remainder, shift the quotient bit in
      rem <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      quo <= {quo[DIV_N_W-2:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == DCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/apm_datapath.sv
// apm_datapath: dB to percent conversion, channel sum, held level and bar
// geometry registers. Depends on apm_pkg and apm_div.
`timescale 1ns / 1ps

module apm_datapath
  import apm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  apm_cfg_t               cfg,
  input  apm_cmd_t               cmd,
  output apm_stat_t              stat,
  input  logic signed [DB_W-1:0] in_peak,
  input  logic                   in_last,
  output logic [LEVEL_W-1:0]     level_q8,
  output logic                   bar_shown,
  output logic [PIX_W-1:0]       bar_x,
  output logic [PIX_W-1:0]       bar_y,
  output logic [PIX_W-1:0]       bar_height
);

  localparam int STEP_PROD_W  = P_W + F_W;
  localparam int SCALE_PROD_W = P_W + LEVEL_W;

  logic [D_W-1:0]        d;
  logic [P_W-1:0]        p;
  logic [STEP_W-1:0]     k;
  logic                  last;
  logic [LEVEL_W-1:0]    pct;
  logic [SUM_W-1:0]      sum;
  logic [CNT_W-1:0]      count;
  logic [LEVEL_W-1:0]    held;
  logic [BAR_PROD_W-1:0] bar_prod;
  logic [PIX_W-1:0]      bar_quo;

  logic [DB_W-1:0]         neg_peak;
  logic [D_W-1:0]          d_in;
  logic [STEP_PROD_W-1:0]  step_round;
  logic [SCALE_PROD_W-1:0] scale_round;
  logic [BAR_SCALE_W-1:0]  bar_scaled;
  logic [LEVEL_W-1:0]      avg;
  logic [LEVEL_W-1:0]      drop;
  logic [LEVEL_W-1:0]      held_next;
  logic [PIX_W-1:0]        room;
  logic [PIX_W-1:0]        bh;
  logic                    show;
  logic                    div_busy;
  logic [DIV_N_W-1:0]      div_quo;
  logic [DIV_N_W-1:0]      div_num;
  logic [DIV_D_W-1:0]      div_den;

  // clamp to the -100 dB .. 0 dB range, then take the magnitude
  assign neg_peak = -in_peak;
  always_comb begin
    priority if (!in_peak[DB_W-1]) begin
      d_in = '0;
    end else if (in_peak < -11'sd1000) begin
      d_in = DB_FLOOR;
    end else begin
      d_in = neg_peak[D_W-1:0];
    end
  end

  assign step_round  = STEP_PROD_W'(p) * STEP_PROD_W'(pow_step(k))
                     + STEP_PROD_W'(1 << (Q_FRAC - 1));
  assign scale_round = SCALE_PROD_W'(p) * SCALE_PROD_W'(FULL_PERCENT_Q8)
                     + SCALE_PROD_W'(1 << (Q_FRAC - 1));
  assign bar_scaled  = BAR_SCALE_W'(bar_prod[BAR_PROD_W-1:BAR_PRE_SHIFT])
                     * BAR_SCALE_W'(RECIP_25);

  assign avg  = (count != '0) ? div_quo[LEVEL_W-1:0] : '0;
  assign drop = held - avg;
  always_comb begin
    priority if (avg >= held) begin
      held_next = avg;
    end else if (drop > cfg.max_fall_q8) begin
      held_next = held - cfg.max_fall_q8;
    end else begin
      held_next = avg;
    end
  end

  assign room = cfg.frame_height - EDGE_PX;
  assign bh   = (bar_quo > room) ? room : bar_quo;
  assign show = cfg.video_ready && (cfg.frame_width != '0) && (cfg.frame_height != '0)
             && (held >= ONE_PERCENT_Q8) && (cfg.frame_height > EDGE_PX);

  assign div_num = sum;
  assign div_den = count;

  apm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign stat.conv_last = (k == STEP_W'(STEPS - 1));
  assign stat.last      = last;
  assign stat.div_busy  = div_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
      held  <= '0;
    end else begin
      if (cmd.accum && (count < CNT_W'(MAX_CHANNELS))) begin
        sum   <= sum + SUM_W'(pct);
        count <= count + 1'b1;
      end
      if (cmd.hold) begin
        held  <= held_next;
        sum   <= '0;
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      d    <= d_in;
      p    <= P_W'(1 << Q_FRAC);
      k    <= '0;
      last <= in_last;
    end
    if (cmd.conv_step) begin
      if (d[k]) begin
        p <= step_round[Q_FRAC +: P_W];
      end
      k <= k + 1'b1;
    end
    if (cmd.scale) begin
      pct <= scale_round[Q_FRAC +: LEVEL_W];
    end
    if (cmd.bar_mul) begin
      bar_prod <= BAR_PROD_W'(held) * BAR_PROD_W'(room);
    end
    if (cmd.bar_scale) begin
      bar_quo <= bar_scaled[RECIP_SHIFT +: PIX_W];
    end
    if (cmd.load_out) begin
      level_q8   <= held;
      bar_shown  <= show;
      bar_height <= show ? bh : '0;
      bar_y      <= show ? (MARGIN_PX + room - bh) : '0;
      bar_x      <= (show && (cfg.frame_width > EDGE_PX)) ? (cfg.frame_width - EDGE_PX) : '0;
    end
  end

  held_full_scale: assert property (@(posedge clk) disable iff (rst)
    held <= FULL_PERCENT_Q8)
    else $error("held level above full scale");

  count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_CHANNELS))
    else $error("channel count past limit");

  hidden_zero: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.load_out) && !bar_shown |-> bar_x == '0 && bar_y == '0 && bar_height == '0)
    else $error("hidden bar carries geometry");

endmodule

// File: hw/rtl/apm_ctrl.sv
// apm_ctrl: sequencer of the peak meter; drives datapath commands and the
// channel handshakes. Depends on apm_pkg.
`timescale 1ns / 1ps

module apm_ctrl
  import apm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  apm_stat_t stat,
  output apm_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV,
    S_SCALE,
    S_ACCUM,
    S_AVG_START,
    S_AVG_WAIT,
    S_HOLD,
    S_BAR_MUL,
    S_BAR_SCALE,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd             = '0;
    state_next      = state;
    cmd.capture     = (state == S_IDLE) && in_valid;
    cmd.conv_step   = (state == S_CONV);
    cmd.scale       = (state == S_SCALE);
    cmd.accum       = (state == S_ACCUM);
    cmd.div_start   = (state == S_AVG_START);
    cmd.hold        = (state == S_HOLD);
    cmd.bar_mul     = (state == S_BAR_MUL);
    cmd.bar_scale   = (state == S_BAR_SCALE);
    cmd.load_out    = (state == S_FINISH) && out_free;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_CONV;
      S_CONV:      if (stat.conv_last) state_next = S_SCALE;
      S_SCALE:     state_next = S_ACCUM;
      S_ACCUM:     state_next = stat.last ? S_AVG_START : S_IDLE;
      S_AVG_START: state_next = S_AVG_WAIT;
      S_AVG_WAIT:  if (!stat.div_busy) state_next = S_HOLD;
      S_HOLD:      state_next = S_BAR_MUL;
      S_BAR_MUL:   state_next = S_BAR_SCALE;
      S_BAR_SCALE: state_next = S_FINISH;
      S_FINISH:    if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // hold the result word until taken, reload once the slot frees
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result word overwritten before taken");

  div_launch: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> stat.div_busy)
    else $error("divider did not start");

  result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result word raised outside finish");

endmodule

// File: dv/apm_level_checker.sv
// apm_level_checker: watches the config port and both channels of the peak meter,
// predicts each level report and compares it field by field. Depends on apm_pkg,
// apm_in_if and apm_out_if.
`timescale 1ns / 1ps

module apm_level_checker
  import apm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  apm_in_if                     in_mon,
  apm_out_if                    out_mon,
  output int unsigned           fail_count,
  output int unsigned           reports_pending,
  output int unsigned           reports_checked,
  output int unsigned           bars_shown
);

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               shown;
    logic [PIX_W-1:0]   x;
    logic [PIX_W-1:0]   y;
    logic [PIX_W-1:0]   height;
  } bar_word_t;

  // 10^(-2^k/200) in Q24, one factor per bit of the attenuation
  localparam longint unsigned ATTEN_Q24 [STEPS] = '{
    64'd16585169, 64'd16395320, 64'd16022117, 64'd15301003, 64'd13954680,
    64'd11606998, 64'd8030080,  64'd3843438,  64'd880481,   64'd46208
  };

  apm_cfg_t          cfg;
  int unsigned       chan_sum;
  int unsigned       chan_count;
  int unsigned       held;
  bar_word_t         bar_expect_q[$];
  bar_word_t         bar_due;
  logic [APB_DATA_W-1:0] reg_now;

  function automatic int unsigned peak_to_percent(input logic signed [DB_W-1:0] peak);
    int              v;
    int unsigned     atten;
    longint unsigned p;
    v = peak;
    if (v > 0) v = 0;
    if (v < -1000) v = -1000;
    atten = -v;
    p = 64'd1 << Q_FRAC;
    for (int k = 0; k < STEPS; k++) begin
      if (atten[k]) p = (p * ATTEN_Q24[k] + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
    end
    return int'((p * FULL_PERCENT_Q8 + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC);
  endfunction

  // Average the open report, move the held level and lay out the bar.
  function automatic bar_word_t close_report();
    bar_word_t   w;
    int unsigned avg;
    int unsigned room;
    int unsigned bh;
    avg = (chan_count != 0) ? chan_sum / chan_count : 0;
    if (avg >= held) held = avg;
    else if (held - avg > cfg.max_fall_q8) held = held - cfg.max_fall_q8;
    else held = avg;
    held = held & 32'h7FFF;
    chan_sum = 0;
    chan_count = 0;
    w = '0;
    w.level = held[LEVEL_W-1:0];
    if (cfg.video_ready && cfg.frame_width != 0 && cfg.frame_height != 0 &&
        held >= ONE_PERCENT_Q8 && cfg.frame_height > EDGE_PX) begin
      room = cfg.frame_height - EDGE_PX;
      bh = int'((longint'(held) * room) / FULL_PERCENT_Q8);
      if (bh > room) bh = room;
      w.shown  = 1'b1;
      w.height = bh[PIX_W-1:0];
      w.y      = PIX_W'(MARGIN_PX + room - bh);
      w.x      = (cfg.frame_width > EDGE_PX) ? cfg.frame_width - EDGE_PX : '0;
    end
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg        = '{video_ready: 1'b0, frame_width: '0, frame_height: '0,
                     max_fall_q8: MAX_FALL_RESET};
      chan_sum   = 0;
      chan_count = 0;
      held       = 0;
      bar_expect_q.delete();
      fail_count      = 0;
      reports_checked = 0;
      bars_shown      = 0;
    end else begin
      if (psel && penable && pready) begin
        case (apm_reg_t'(paddr[3:2]))
          REG_VIDEO_READY:  reg_now = APB_DATA_W'(cfg.video_ready);
          REG_FRAME_WIDTH:  reg_now = APB_DATA_W'(cfg.frame_width);
          REG_FRAME_HEIGHT: reg_now = APB_DATA_W'(cfg.frame_height);
          default:          reg_now = APB_DATA_W'(cfg.max_fall_q8);
        endcase
        if (pwrite) begin
          case (apm_reg_t'(paddr[3:2]))
            REG_VIDEO_READY:  cfg.video_ready  = pwdata[0];
            REG_FRAME_WIDTH:  cfg.frame_width  = pwdata[PIX_W-1:0];
            REG_FRAME_HEIGHT: cfg.frame_height = pwdata[PIX_W-1:0];
            default:          cfg.max_fall_q8  = pwdata[LEVEL_W-1:0];
          endcase
        end else if (prdata !== reg_now) begin
          $error("prdata mismatch at 0x%0h: expected %0d, got %0d", paddr, reg_now, prdata);
          fail_count++;
        end
      end

      if (out_mon.valid && out_mon.ready) begin
        if (bar_expect_q.size() == 0) begin
          $error("level report with none pending: level_q8 %0d", out_mon.level_q8);
          fail_count++;
        end else begin
          bar_due = bar_expect_q.pop_front();
          if (out_mon.level_q8 !== bar_due.level) begin
            $error("level_q8 mismatch: expected %0d, got %0d", bar_due.level, out_mon.level_q8);
            fail_count++;
          end
          if (out_mon.bar_shown !== bar_due.shown) begin
            $error("bar_shown mismatch: expected %0d, got %0d", bar_due.shown, out_mon.bar_shown);
            fail_count++;
          end
          if (out_mon.bar_x !== bar_due.x) begin
            $error("bar_x mismatch: expected %0d, got %0d", bar_due.x, out_mon.bar_x);
            fail_count++;
          end
          if (out_mon.bar_y !== bar_due.y) begin
            $error("bar_y mismatch: expected %0d, got %0d", bar_due.y, out_mon.bar_y);
            fail_count++;
          end
          if (out_mon.bar_height !== bar_due.height) begin
            $error("bar_height mismatch: expected %0d, got %0d", bar_due.height,
                   out_mon.bar_height);
            fail_count++;
          end
          reports_checked++;
          if (bar_due.shown) bars_shown++;
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        // drop channels past the limit, but still honor their closing flag
        if (chan_count < MAX_CHANNELS) begin
          chan_sum += peak_to_percent(in_mon.peak_db_tenths);
          chan_count++;
        end
        if (in_mon.last_channel) bar_expect_q.push_back(close_report());
      end
    end
    reports_pending = bar_expect_q.size();
  end

endmodule

// File: dv/tb_audio_peak_meter_bar.sv
// tb_audio_peak_meter_bar: drives peak words and register settings into the meter,
// with random idling on both channels; apm_level_checker does the checking.
// Depends on apm_pkg, both channel interfaces, the block and the checker.
`timescale 1ns / 1ps

module tb_audio_peak_meter_bar;
  import apm_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 12;
  localparam int RANDOM_PHASES   = 10;
  localparam int PHASE_WORDS     = 85;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 100;
  localparam int STALL_LIMIT     = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic        src_idle = 1'b1;
  logic        sink_idle = 1'b1;
  logic        hold_off_req = 1'b0;
  int unsigned words_sent = 0;
  int unsigned settings_used = 0;

  int unsigned fail_count;
  int unsigned reports_pending;
  int unsigned reports_checked;
  int unsigned bars_shown;

  apm_in_if  in_ch ();
  apm_out_if out_ch ();

  audio_peak_meter_bar i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  apm_level_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .reports_pending (reports_pending),
    .reports_checked (reports_checked),
    .bars_shown      (bars_shown)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  task automatic apb_access(input logic wr, input apm_reg_t idx,
                            input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  // Write every register with junk above its width, then read all back.
  task automatic program_meter(input logic vr, input logic [PIX_W-1:0] w,
                               input logic [PIX_W-1:0] h, input logic [LEVEL_W-1:0] fall);
    apb_access(1'b1, REG_VIDEO_READY, (APB_DATA_W'($urandom) << 1) | APB_DATA_W'(vr));
    apb_access(1'b1, REG_FRAME_WIDTH, (APB_DATA_W'($urandom) << PIX_W) | APB_DATA_W'(w));
    apb_access(1'b1, REG_FRAME_HEIGHT, (APB_DATA_W'($urandom) << PIX_W) | APB_DATA_W'(h));
    apb_access(1'b1, REG_MAX_FALL, (APB_DATA_W'($urandom) << LEVEL_W) | APB_DATA_W'(fall));
    apb_access(1'b0, REG_VIDEO_READY, '0);
    apb_access(1'b0, REG_FRAME_WIDTH, '0);
    apb_access(1'b0, REG_FRAME_HEIGHT, '0);
    apb_access(1'b0, REG_MAX_FALL, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  task automatic send_peak(input logic signed [DB_W-1:0] peak, input logic last);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.peak_db_tenths <= peak;
    in_ch.last_channel   <= last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    words_sent++;
    @(negedge clk);
  endtask

  // Hold the input until every report is back and the block has gone quiet.
  task automatic drain_reports();
    in_ch.valid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [DB_W-1:0] draw_peak();
    int v;
    case ($urandom_range(0, 9))
      0:       v = int'($urandom);
      1:       v = $urandom_range(0, 1) ? 0 : -1000;
      2, 3:    v = -int'($urandom_range(0, 1000));
      default: v = -int'($urandom_range(0, 400));
    endcase
    return v[DB_W-1:0];
  endfunction

  initial begin : result_sink
    int unsigned gap;
    out_ch.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      gap = sink_idle ? $urandom_range(0, 9) : 0;
      if (hold_off_req) begin
        gap = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int unsigned nch;
    in_ch.valid          = 1'b0;
    in_ch.peak_db_tenths = '0;
    in_ch.last_channel   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: bar hidden, level extremes and dB clamping
    send_peak(DB_W'(0), 1'b1);
    send_peak(DB_W'(-1000), 1'b1);
    send_peak(DB_W'(1023), 1'b1);
    send_peak(DB_W'(-1024), 1'b1);
    send_peak(DB_W'(-1001), 1'b1);
    send_peak(DB_W'(-1), 1'b0);
    send_peak(DB_W'(-999), 1'b1);
    drain_reports();

    program_meter(1'b1, 12'd640, 12'd480, MAX_FALL_RESET);
    // channels past the limit must not touch the average
    for (int c = 0; c < 10; c++) begin
      send_peak(DB_W'((c < MAX_CHANNELS) ? -60 * c : -1000), c == 9);
    end
    send_peak(DB_W'(-500), 1'b1);
    drain_reports();

    program_meter(1'b1, 12'd30, 12'd41, 15'd0);
    send_peak(DB_W'(-200), 1'b1);
    send_peak(DB_W'(0), 1'b1);
    drain_reports();

    program_meter(1'b1, 12'd4095, 12'd40, 15'd25600);
    send_peak(DB_W'(0), 1'b1);
    drain_reports();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: program_meter(1'b1, 12'd640, 12'd480, MAX_FALL_RESET);
        1: program_meter(1'b1, 12'd4095, 12'd4095, 15'd0);
        2: program_meter(1'b1, 12'd4095, 12'd4095, 15'd25600);
        3: program_meter(1'b0, 12'd1920, 12'd1080, 15'($urandom_range(0, 25600)));
        4: program_meter(1'b1, 12'd0, 12'd1080, 15'($urandom_range(0, 25600)));
        5: program_meter(1'b1, 12'd1920, 12'd0, 15'($urandom_range(0, 25600)));
        6: program_meter(1'b1, 12'd39, 12'd41, 15'h7FFF);
        default: program_meter($urandom_range(0, 3) != 0, 12'($urandom), 12'($urandom),
                               $urandom_range(0, 1) ? 15'($urandom_range(0, 25600))
                                                    : 15'($urandom));
      endcase
      src_idle  = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      if (ph == 2) begin
        // stall the result side long enough to back up the input
        src_idle     = 1'b0;
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < PHASE_WORDS; n += nch) begin
        nch = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_CHANNELS + 1, MAX_CHANNELS + 4)
                                          : $urandom_range(1, MAX_CHANNELS);
        for (int c = 0; c < nch; c++) send_peak(draw_peak(), c == nch - 1);
      end
      drain_reports();
    end

    $display("Checked %0d level reports (%0d with a bar) from %0d peak words", reports_checked,
             bars_shown, words_sent);
    $display("across %0d register settings, including a %0d-cycle result stall.",
             settings_used, HOLD_OFF_CYCLES);
    if (fail_count == 0 && reports_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
